FILE: design/stereo_adc_oversample_peak_meter_unit_macros.svh
// ----------------------------------------------------------------------------
// stereo adc oversample peak meter assertion macros
// concurrent checks that drop out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef STEREO_ADC_OVERSAMPLE_PEAK_METER_UNIT_MACROS_SVH
`define STEREO_ADC_OVERSAMPLE_PEAK_METER_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define SOPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SOPM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SOPM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SOPM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/sopm_pkg.sv
// ----------------------------------------------------------------------------
// sopm_pkg
// types, constants and helpers for the stereo adc oversample peak meter
// ----------------------------------------------------------------------------
package sopm_pkg;

  localparam int FRAME_VALUES = 256;
  localparam int POS_W        = (FRAME_VALUES > 2) ? $clog2(FRAME_VALUES) : 1;

  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_W        = 2;
  localparam int CNT_W        = 3;

  localparam logic [2:0] PH_FIRST_L = 3'd0;
  localparam logic [2:0] PH_FIRST_R = 3'd1;
  localparam logic [2:0] PH_LAST    = 3'd7;

  // floor(p / 273) == (p * 30728) >> 23 for p <= 32768
  localparam logic [14:0] LVL_RECIP = 15'd30728;
  localparam int          LVL_SHIFT = 23;

  typedef struct packed {
    logic [11:0] adc_sample;
    logic        peak_clear;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] pcm_value;
    logic               channel;
    logic               frame_last;
    logic [31:0]        frame_number;
    logic [6:0]         level_left;
    logic [6:0]         level_right;
  } out_beat_t;

  function automatic logic [6:0] lvl_div(input logic [15:0] pk);
    logic [30:0] prod;
    prod = 31'(pk) * 31'(LVL_RECIP);
    return prod[LVL_SHIFT +: 7];
  endfunction

  function automatic logic [15:0] abs16(input logic [15:0] v);
    return v[15] ? 16'(~v + 16'd1) : v;
  endfunction

endpackage

FILE: design/stereo_adc_oversample_peak_meter_unit.sv
// ----------------------------------------------------------------------------
// stereo_adc_oversample_peak_meter_unit
// stereo adc front end: 4x oversampling or direct scaling, peak meter, framing
// ----------------------------------------------------------------------------
// Takes one adc conversion beat per cycle, sustained, in either mode. A beat
// is captured in an input register, processed from there once the result
// queue has room, and its results are written into a four-entry result
// queue. Direct mode gives one result per beat; oversampling mode gives
// nothing for seven beats and then left and right on the eighth. The input
// side stalls only when the result queue cannot take two more results.
// Levels reflect the peak holds after each result.
`include "stereo_adc_oversample_peak_meter_unit_macros.svh"

module stereo_adc_oversample_peak_meter_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sopm_pkg::in_beat_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sopm_pkg::out_beat_t   out_data
);

  logic                         os_r;
  logic                         in_vld_r, in_vld_nxt;
  sopm_pkg::in_beat_t           in_r;

  logic [2:0]                   phase_r, phase_nxt;
  logic [13:0]                  ls_r, ls_nxt, rs_r, rs_nxt;
  logic [sopm_pkg::POS_W-1:0]   pos_r, pos_a, pos_b;
  logic [31:0]                  fc_r, fc_a, fc_b;
  logic [15:0]                  pl_r, pr_r, pl0, pr0, pl_a, pr_a, pr_b;

  sopm_pkg::out_beat_t          fifo_r [sopm_pkg::FIFO_DEPTH];
  logic [sopm_pkg::PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [sopm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  logic                         space_ok, fire, emit0, emit1, pop;
  logic                         ch0, last0, last1;
  logic [13:0]                  x14;
  logic [15:0]                  v_left, v_right, v_dir, v0, mag0, mag1;
  sopm_pkg::out_beat_t          res0, res1;

  assign cfg_ready = 1'b1;

  // queue must hold two more results before a beat leaves the input register
  assign space_ok  = cnt_r <= sopm_pkg::CNT_W'(sopm_pkg::FIFO_DEPTH - 2);
  assign fire      = in_vld_r && space_ok;
  assign in_ready  = !in_vld_r || space_ok;
  assign in_vld_nxt = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : in_vld_r);

  assign emit0 = fire && (!os_r || phase_r == sopm_pkg::PH_LAST);
  assign emit1 = fire && os_r && phase_r == sopm_pkg::PH_LAST;

  assign x14 = {2'b00, in_r.adc_sample};

  // accumulators
  always_comb begin
    ls_nxt = ls_r;
    rs_nxt = rs_r;
    if (os_r) begin
      if (phase_r == sopm_pkg::PH_FIRST_L) begin
        ls_nxt = x14;
      end else if (phase_r == sopm_pkg::PH_FIRST_R) begin
        rs_nxt = x14;
      end else if (!phase_r[0]) begin
        ls_nxt = ls_r + x14;
      end else begin
        rs_nxt = rs_r + x14;
      end
    end
  end

  assign phase_nxt = phase_r + 3'd1;

  // centered and scaled values
  assign v_left  = {~ls_nxt[13], ls_nxt[12:0], 2'b00};
  assign v_right = {~rs_nxt[13], rs_nxt[12:0], 2'b00};
  assign v_dir   = {{2{~in_r.adc_sample[11]}}, in_r.adc_sample[10:0], 3'b000};
  assign v0      = os_r ? v_left : v_dir;
  assign ch0     = os_r ? 1'b0 : phase_r[0];

  assign mag0 = sopm_pkg::abs16(v0);
  assign mag1 = sopm_pkg::abs16(v_right);

  // peak holds
  assign pl0  = in_r.peak_clear ? 16'd0 : pl_r;
  assign pr0  = in_r.peak_clear ? 16'd0 : pr_r;
  assign pl_a = (emit0 && !ch0 && mag0 > pl0) ? mag0 : pl0;
  assign pr_a = (emit0 &&  ch0 && mag0 > pr0) ? mag0 : pr0;
  assign pr_b = (emit1 && mag1 > pr_a) ? mag1 : pr_a;

  // framing
  assign last0 = pos_r == sopm_pkg::POS_W'(sopm_pkg::FRAME_VALUES - 1);
  assign pos_a = !emit0 ? pos_r : (last0 ? '0 : pos_r + sopm_pkg::POS_W'(1));
  assign fc_a  = fc_r + 32'(emit0 && last0);
  assign last1 = pos_a == sopm_pkg::POS_W'(sopm_pkg::FRAME_VALUES - 1);
  assign pos_b = !emit1 ? pos_a : (last1 ? '0 : pos_a + sopm_pkg::POS_W'(1));
  assign fc_b  = fc_a + 32'(emit1 && last1);

  always_comb begin
    res0.pcm_value    = v0;
    res0.channel      = ch0;
    res0.frame_last   = last0;
    res0.frame_number = fc_a;
    res0.level_left   = sopm_pkg::lvl_div(pl_a);
    res0.level_right  = sopm_pkg::lvl_div(pr_a);
    res1.pcm_value    = v_right;
    res1.channel      = 1'b1;
    res1.frame_last   = last1;
    res1.frame_number = fc_b;
    res1.level_left   = sopm_pkg::lvl_div(pl_a);
    res1.level_right  = sopm_pkg::lvl_div(pr_b);
  end

  // result queue
  assign out_valid = cnt_r != '0;
  assign out_data  = fifo_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign cnt_nxt   = cnt_r + sopm_pkg::CNT_W'(emit0) + sopm_pkg::CNT_W'(emit1)
                     - sopm_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (emit0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (emit1) begin
      fifo_r[wr_ptr_r + sopm_pkg::PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      os_r     <= 1'b1;
      in_vld_r <= 1'b0;
      phase_r  <= '0;
      ls_r     <= '0;
      rs_r     <= '0;
      pos_r    <= '0;
      fc_r     <= '0;
      pl_r     <= '0;
      pr_r     <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        os_r <= cfg_data;
      end
      in_vld_r <= in_vld_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
        ls_r    <= ls_nxt;
        rs_r    <= rs_nxt;
        pos_r   <= pos_b;
        fc_r    <= fc_b;
        pl_r    <= pl_a;
        pr_r    <= pr_b;
      end
      wr_ptr_r <= wr_ptr_r + sopm_pkg::PTR_W'(emit0) + sopm_pkg::PTR_W'(emit1);
      rd_ptr_r <= rd_ptr_r + sopm_pkg::PTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  // checks
  `SOPM_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= sopm_pkg::CNT_W'(sopm_pkg::FIFO_DEPTH))
  `SOPM_ASSERT_IMP(a_ptr_match, clk, rst_n, 1'b1, (wr_ptr_r - rd_ptr_r) == cnt_r[sopm_pkg::PTR_W-1:0])
  `SOPM_ASSERT_IMP(a_pair_phase, clk, rst_n, emit1, os_r && phase_r == sopm_pkg::PH_LAST)
  `SOPM_ASSERT_NXT(a_peak_hold_l, clk, rst_n, fire && !in_r.peak_clear, pl_r >= $past(pl_r))
  `SOPM_ASSERT_NXT(a_peak_hold_r, clk, rst_n, fire && !in_r.peak_clear, pr_r >= $past(pr_r))

endmodule

FILE: test/stereo_adc_oversample_peak_meter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_adc_oversample_peak_meter_unit_tb
// Drives round-robin adc conversion beats through the unit in both direct and
// 4x oversampling modes, with random idling on both sides and a long receiver
// hold-off. A behavioral copy of the datapath predicts pcm values, framing and
// peak levels for every accepted beat; each result beat is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module stereo_adc_oversample_peak_meter_unit_tb;

  localparam int   OS_OFFSET       = 8192;
  localparam int   DIRECT_OFFSET   = 2048;
  localparam int   OS_GAIN         = 4;
  localparam int   DIRECT_GAIN     = 8;
  localparam int   LEVEL_DIV       = 273;
  localparam logic CH_LEFT         = 1'b0;
  localparam logic CH_RIGHT        = 1'b1;
  localparam logic MODE_DIRECT     = 1'b0;
  localparam logic MODE_OVERSAMPLE = 1'b1;
  localparam int   SETTLE_CYCLES   = 6;
  localparam int   WDOG_LIMIT      = 2000;
  localparam int   LONG_HOLD       = 300;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;
  logic                in_valid;
  logic                in_ready;
  sopm_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_ready;
  sopm_pkg::out_beat_t out_data;

  // predictor state
  logic                os_mode;
  logic [2:0]          rr_phase;
  logic [13:0]         sum_left;
  logic [13:0]         sum_right;
  int                  frame_pos;
  logic [31:0]         frame_cnt;
  int                  peak_l;
  int                  peak_r;
  sopm_pkg::out_beat_t pcm_expected_q[$];

  int  err_cnt;
  int  quiet_cycles;
  bit  idle_on;
  int  hold_req;

  stereo_adc_oversample_peak_meter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic emit_pcm(input int v, input logic ch);
    sopm_pkg::out_beat_t r;
    int                  mag;
    logic                last;
    mag = (v < 0) ? -v : v;
    if (ch == CH_LEFT) begin
      if (mag > peak_l) peak_l = mag;
    end else begin
      if (mag > peak_r) peak_r = mag;
    end
    last = (frame_pos >= sopm_pkg::FRAME_VALUES - 1);
    if (last) begin
      frame_pos = 0;
      frame_cnt = frame_cnt + 32'd1;
    end else begin
      frame_pos = frame_pos + 1;
    end
    r.pcm_value    = 16'(v);
    r.channel      = ch;
    r.frame_last   = last;
    r.frame_number = frame_cnt;
    r.level_left   = 7'(peak_l / LEVEL_DIV);
    r.level_right  = 7'(peak_r / LEVEL_DIV);
    pcm_expected_q.push_back(r);
  endtask

  task automatic predict_conversion(input sopm_pkg::in_beat_t b);
    int x;
    x = int'(b.adc_sample);
    if (b.peak_clear) begin
      peak_l = 0;
      peak_r = 0;
    end
    if (os_mode == MODE_OVERSAMPLE) begin
      if (rr_phase == sopm_pkg::PH_FIRST_L) sum_left = 14'(x);
      else if (rr_phase == sopm_pkg::PH_FIRST_R) sum_right = 14'(x);
      else if (rr_phase[0] == CH_LEFT) sum_left = sum_left + 14'(x);
      else sum_right = sum_right + 14'(x);
      if (rr_phase == sopm_pkg::PH_LAST) begin
        emit_pcm((int'(sum_left) - OS_OFFSET) * OS_GAIN, CH_LEFT);
        emit_pcm((int'(sum_right) - OS_OFFSET) * OS_GAIN, CH_RIGHT);
      end
    end else begin
      emit_pcm((x - DIRECT_OFFSET) * DIRECT_GAIN, rr_phase[0]);
    end
    rr_phase = rr_phase + 3'd1;
  endtask

  // result check, prediction and watchdog
  always @(posedge clk) begin : result_check
    sopm_pkg::out_beat_t want;
    if (!rst_n) begin
      os_mode      = MODE_OVERSAMPLE;
      rr_phase     = '0;
      sum_left     = '0;
      sum_right    = '0;
      frame_pos    = 0;
      frame_cnt    = '0;
      peak_l       = 0;
      peak_r       = 0;
      quiet_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pcm_expected_q.size() == 0) begin
          report_mismatch("unexpected result, pcm_value", out_data.pcm_value, 0);
        end else begin
          want = pcm_expected_q.pop_front();
          if (out_data.pcm_value !== want.pcm_value)
            report_mismatch("pcm_value", out_data.pcm_value, want.pcm_value);
          if (out_data.channel !== want.channel)
            report_mismatch("channel", out_data.channel, want.channel);
          if (out_data.frame_last !== want.frame_last)
            report_mismatch("frame_last", out_data.frame_last, want.frame_last);
          if (out_data.frame_number !== want.frame_number)
            report_mismatch("frame_number", out_data.frame_number, want.frame_number);
          if (out_data.level_left !== want.level_left)
            report_mismatch("level_left", out_data.level_left, want.level_left);
          if (out_data.level_right !== want.level_right)
            report_mismatch("level_right", out_data.level_right, want.level_right);
        end
      end
      if (cfg_valid && cfg_ready) os_mode = cfg_data;
      if (in_valid && in_ready) predict_conversion(in_data);
      if ((out_valid && out_ready) || (cfg_valid && cfg_ready) || (in_valid && in_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", WDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: random stalls plus a requested long hold-off
  initial begin : receiver
    int hold_cnt;
    int stall_cnt;
    hold_cnt  = 0;
    stall_cnt = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt != 0) begin
        out_ready <= 1'b0;
        hold_cnt--;
      end else if (stall_cnt != 0) begin
        out_ready <= 1'b0;
        stall_cnt--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_cnt = $urandom_range(1, 14) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // called and returns at a falling edge; valid stays high between beats unless idling
  task automatic send_conversion(input logic [11:0] smp, input logic clr);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{adc_sample: smp, peak_clear: clr};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 12'd0;
      1:       return 12'hfff;
      2:       return 12'(DIRECT_OFFSET);
      3:       return 12'(DIRECT_OFFSET - 1);
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_conversion(pick_sample(), $urandom_range(0, 15) == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pcm_expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reset mode is oversampling: full-scale low then high groups
  task automatic test_oversample_extremes();
    send_conversion(12'd0, 1'b1);
    repeat (7) send_conversion(12'd0, 1'b0);
    send_conversion(12'hfff, 1'b1);
    repeat (7) send_conversion(12'hfff, 1'b0);
  endtask

  task automatic test_direct_extremes();
    write_mode(MODE_DIRECT);
    send_conversion(12'd0, 1'b0);
    send_conversion(12'hfff, 1'b0);
    send_conversion(12'(DIRECT_OFFSET), 1'b0);
    send_conversion(12'(DIRECT_OFFSET - 1), 1'b1);
    send_conversion(12'hfff, 1'b0);
    send_conversion(12'd0, 1'b0);
  endtask

  // group started in direct mode finished in oversampling mode
  task automatic test_mode_switch_mid_group();
    write_mode(MODE_OVERSAMPLE);
    send_conversion(12'd1234, 1'b0);
    send_conversion(12'd3000, 1'b0);
  endtask

  task automatic test_random_modes();
    repeat (10) begin
      write_mode(1'($urandom_range(0, 1)));
      send_random($urandom_range(60, 160));
    end
  endtask

  task automatic test_output_backpressure();
    write_mode(MODE_DIRECT);
    hold_req = LONG_HOLD;
    send_random(100);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    write_mode(1'($urandom_range(0, 1)));
    send_random(250);
    write_mode(~os_mode);
    send_random(150);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    err_cnt   = 0;
    idle_on   = 1'b1;
    hold_req  = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_oversample_extremes();
    test_direct_extremes();
    test_mode_switch_mid_group();
    test_random_modes();
    test_output_backpressure();
    test_full_rate();

    drain();
    repeat (10) @(negedge clk);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
